>>> rtl/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;

  localparam int unsigned CostW  = 28;
  localparam int unsigned SumW   = 36;
  localparam int unsigned SqW    = 64;
  localparam int unsigned ScoreW = 29;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned TolW   = 16;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned WideW  = 128;
  localparam int unsigned RootW  = 38;

  localparam logic [ModeW-1:0] MODE_WORST      = 4'd0;
  localparam logic [ModeW-1:0] MODE_MEAN_PEN   = 4'd1;
  localparam logic [ModeW-1:0] MODE_MAX_TOTAL  = 4'd2;
  localparam logic [ModeW-1:0] MODE_MEAN_TOTAL = 4'd3;
  localparam logic [ModeW-1:0] MODE_MAX_START  = 4'd4;
  localparam logic [ModeW-1:0] MODE_MEAN_START = 4'd5;
  localparam logic [ModeW-1:0] MODE_WORST_STD  = 4'd6;
  localparam logic [ModeW-1:0] MODE_MEAN_STD   = 4'd7;
  localparam logic [ModeW-1:0] MODE_FOURTH     = 4'd8;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_TOL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_SQ_A, ST_SQ_B, ST_ROOT, ST_DIV_SUM, ST_DIV_STD, ST_OUT
  } sps_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start_sq;
    logic sq_step;
    logic root_init;
    logic root_step;
    logic div_init_sum;
    logic div_init_std;
    logic div_step;
    logic load_out;
    logic clear;
  } sps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_empty;
    logic is_last;
    logic need_std;
    logic need_div;
    logic root_done;
    logic div_done;
  } sps_sts_t;

endpackage

>>> rtl/sps_ctrl.sv
`timescale 1ns / 1ps
module sps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sps_pkg::sps_sts_t sts,
  output sps_pkg::sps_cmd_t cmd
);
  import sps_pkg::*;

  sps_state_t state_r, state_nxt;
  logic       acc;

  assign acc = in_tready && in_tvalid;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && sts.is_empty) state_nxt = ST_OUT;
        else if (acc && sts.is_last) state_nxt = ST_START;
      end
      ST_START: begin
        if (sts.need_std) state_nxt = ST_SQ_A;
        else if (sts.need_div) state_nxt = ST_DIV_SUM;
        else state_nxt = ST_OUT;
      end
      ST_SQ_A:  state_nxt = ST_SQ_B;
      ST_SQ_B:  state_nxt = ST_ROOT;
      ST_ROOT:  if (sts.root_done) state_nxt = ST_DIV_STD;
      ST_DIV_STD: if (sts.div_done) state_nxt = sts.need_div ? ST_DIV_SUM : ST_OUT;
      ST_DIV_SUM: if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = acc;
      end
      ST_START: begin
        cmd.start_sq     = sts.need_std;
        cmd.div_init_sum = !sts.need_std && sts.need_div;
        cmd.load_out     = !sts.need_std && !sts.need_div;
      end
      ST_SQ_A:  cmd.sq_step = 1'b1;
      ST_SQ_B: begin
        cmd.sq_step   = 1'b1;
        cmd.root_init = 1'b1;
      end
      ST_ROOT: begin
        cmd.root_step    = 1'b1;
        cmd.div_init_std = sts.root_done;
      end
      ST_DIV_STD: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_init_sum = sts.need_div;
          cmd.load_out     = !sts.need_div;
        end
      end
      ST_DIV_SUM: begin
        cmd.div_step = 1'b1;
        cmd.load_out = sts.div_done;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        cmd.clear  = out_tready;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/sps_dp.sv
`timescale 1ns / 1ps
module sps_dp #(
  parameter int unsigned MAX_SAMPLES    = 256,
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sps_pkg::CostW-1:0]    tot_cost,
  input  logic [sps_pkg::CostW-1:0]    startup_cost,
  input  logic [sps_pkg::CostW-1:0]    envelope,
  input  logic                         last,
  input  logic                         empty_req,
  input  logic [sps_pkg::ModeW-1:0]    score_mode,
  input  logic [sps_pkg::TolW-1:0]     tolerance_q12,
  input  sps_pkg::sps_cmd_t            cmd,
  output sps_pkg::sps_sts_t            sts,
  output logic [sps_pkg::ScoreW-1:0]   score,
  output logic [sps_pkg::IdxW-1:0]     candidate_index
);
  import sps_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned NW   = 9;
  localparam logic [SumW-1:0] SumMax = '1;

  logic [CostW-1:0] max_pen_r, max_tot_r, max_st_r;
  logic [CostW-1:0] top_r [4];
  logic [SumW-1:0]  pen_sum_r, tot_sum_r, st_sum_r;
  logic [SqW-1:0]   sq_sum_r;
  logic [CntW-1:0]  seen_r;
  logic [IdxW-1:0]  cand_r;

  // penalty of the incoming word
  logic [CostW+TolW-1:0] lhs, rhs;
  logic [CostW-1:0]  pen;
  logic [2*CostW-1:0] sq;
  logic [SqW:0]       sq_add;
  logic [SumW:0]      ps_add, ts_add, ss_add;
  logic               do_acc;

  assign lhs = (CostW+TolW)'({tot_cost, 12'd0});
  assign rhs = envelope * tolerance_q12;
  assign pen = (lhs > rhs && tot_cost > envelope) ? tot_cost - envelope : '0;
  assign sq  = pen * pen;
  assign sq_add = {1'b0, sq_sum_r} + (SqW+1)'(sq);
  assign ps_add = {1'b0, pen_sum_r} + (SumW+1)'(pen);
  assign ts_add = {1'b0, tot_sum_r} + (SumW+1)'(tot_cost);
  assign ss_add = {1'b0, st_sum_r} + (SumW+1)'(startup_cost);
  assign do_acc = cmd.accept && !empty_req && (seen_r < CntW'(MAX_SAMPLES));

  logic [NW-1:0] n;
  assign n = NW'(seen_r);

  // accumulate samples, clear after the score word leaves
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      max_pen_r <= '0; max_tot_r <= '0; max_st_r <= '0;
      for (int k = 0; k < 4; k++) top_r[k] <= '0;
      pen_sum_r <= '0; tot_sum_r <= '0; st_sum_r <= '0;
      sq_sum_r <= '0; seen_r <= '0;
    end else if (do_acc) begin
      if (pen > max_pen_r) max_pen_r <= pen;
      if (tot_cost > max_tot_r) max_tot_r <= tot_cost;
      if (startup_cost > max_st_r) max_st_r <= startup_cost;
      pen_sum_r <= ps_add[SumW] ? SumMax : ps_add[SumW-1:0];
      tot_sum_r <= ts_add[SumW] ? SumMax : ts_add[SumW-1:0];
      st_sum_r  <= ss_add[SumW] ? SumMax : ss_add[SumW-1:0];
      sq_sum_r  <= sq_add[SqW] ? '1 : sq_add[SqW-1:0];
      // sorted insert into top four
      if (pen > top_r[0]) begin
        top_r[0] <= pen; top_r[1] <= top_r[0]; top_r[2] <= top_r[1]; top_r[3] <= top_r[2];
      end else if (pen > top_r[1]) begin
        top_r[1] <= pen; top_r[2] <= top_r[1]; top_r[3] <= top_r[2];
      end else if (pen > top_r[2]) begin
        top_r[2] <= pen; top_r[3] <= top_r[2];
      end else if (pen > top_r[3]) begin
        top_r[3] <= pen;
      end
      seen_r <= seen_r + 1'b1;
    end
  end

  // candidate counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else if (cmd.clear) begin
      cand_r <= (32'(cand_r) + 1 >= MAX_CANDIDATES) ? '0 : cand_r + 1'b1;
    end
  end

  // variance: n*sumsq - sum^2 in 128 bits, from 32-bit halves of sumsq and 18-bit halves of sum
  logic [1:0]       sq_ph_r;
  logic [WideW-1:0] v_r;
  logic [WideW-1:0] a_r, b_r;
  logic [31:0]      sq_lo, sq_hi;
  logic [17:0]      s_lo, s_hi;
  assign sq_lo = sq_sum_r[31:0];
  assign sq_hi = sq_sum_r[63:32];
  assign s_lo  = pen_sum_r[17:0];
  assign s_hi  = pen_sum_r[35:18];

  always_ff @(posedge clk) begin
    if (cmd.start_sq) begin
      a_r <= WideW'(n * sq_lo);
      b_r <= WideW'(s_lo * s_lo) + (WideW'(s_hi * s_hi) << 36);
    end else if (cmd.sq_step && !cmd.root_init) begin
      a_r <= a_r + (WideW'(n * sq_hi) << 32);
      b_r <= b_r + (WideW'(s_lo * s_hi) << 19);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) v_r <= (a_r > b_r) ? a_r - b_r : '0;
  end

  // digit-by-digit square root, one result bit per cycle; the square of the
  // partial root is kept and grown by shifts and adds
  logic [RootW-1:0]   root_r;
  logic [2*RootW-1:0] root_sq_r;
  logic [5:0]         rbit_r;
  logic [RootW-1:0]   rt;
  logic [2*RootW-1:0] rt2;
  assign rt  = root_r | (RootW'(1) << rbit_r);
  assign rt2 = root_sq_r + ((2*RootW)'(root_r) << (rbit_r + 6'd1))
             + ((2*RootW)'(1) << {rbit_r, 1'b0});
  assign sts.root_done = (rbit_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      root_r    <= '0;
      root_sq_r <= '0;
      rbit_r    <= 6'(RootW - 1);
    end else if (cmd.root_step) begin
      if (WideW'(rt2) <= v_r) begin
        root_r    <= rt;
        root_sq_r <= rt2;
      end
      if (rbit_r != '0) rbit_r <= rbit_r - 1'b1;
    end
  end

  // restoring divider by n, one quotient bit per cycle
  logic [RootW-1:0] dq_r;
  logic [NW-1:0]    drem_r;
  logic [5:0]       dcnt_r;
  logic [NW:0]      dtrial;
  logic [RootW-1:0] std_r, mean_r;
  logic             dstd_r;
  logic [SumW-1:0]  sum_sel;

  always_comb begin
    case (score_mode)
      MODE_MEAN_TOTAL: sum_sel = tot_sum_r;
      MODE_MEAN_START: sum_sel = st_sum_r;
      default:         sum_sel = pen_sum_r;
    endcase
  end

  assign dtrial = {drem_r, dq_r[RootW-1]};
  assign sts.div_done = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_init_std || cmd.div_init_sum) begin
      dq_r   <= cmd.div_init_std ? (cmd.root_step && WideW'(rt2) <= v_r ? rt : root_r)
                                 : RootW'(sum_sel);
      drem_r <= '0;
      dcnt_r <= 6'(RootW);
      dstd_r <= cmd.div_init_std;
    end else if (cmd.div_step && dcnt_r != '0) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (dtrial >= {1'b0, n}) begin
        drem_r <= NW'(dtrial - {1'b0, n});
        dq_r   <= {dq_r[RootW-2:0], 1'b1};
      end else begin
        drem_r <= dtrial[NW-1:0];
        dq_r   <= {dq_r[RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && dcnt_r == 6'd1) begin
      if (dstd_r) std_r <= {dq_r[RootW-2:0], dtrial >= {1'b0, n}};
      else        mean_r <= {dq_r[RootW-2:0], dtrial >= {1'b0, n}};
    end
  end

  // final score selection
  logic [RootW:0]    raw;
  logic [1:0]        fidx;
  logic [ScoreW-1:0] score_r;
  logic [RootW-1:0]  mean_now;
  assign fidx = (n >= NW'(4)) ? 2'd3 : 2'(n - 1'b1);
  assign mean_now = (cmd.div_step && dcnt_r == 6'd1 && !dstd_r)
                    ? {dq_r[RootW-2:0], dtrial >= {1'b0, n}} : mean_r;

  always_comb begin
    case (score_mode) inside
      MODE_WORST:      raw = (RootW+1)'(max_pen_r);
      MODE_MEAN_PEN,
      MODE_MEAN_TOTAL,
      MODE_MEAN_START: raw = (RootW+1)'(mean_now);
      MODE_MAX_TOTAL:  raw = (RootW+1)'(max_tot_r);
      MODE_MAX_START:  raw = (RootW+1)'(max_st_r);
      MODE_WORST_STD:  raw = (RootW+1)'(max_pen_r) + (RootW+1)'(std_r);
      MODE_MEAN_STD:   raw = (RootW+1)'(mean_now) + (RootW+1)'(std_r);
      MODE_FOURTH:     raw = (RootW+1)'(top_r[fidx]);
      default:         raw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && empty_req) score_r <= '1;
    else if (cmd.load_out)
      score_r <= (raw > (RootW+1)'({ScoreW{1'b1}})) ? '1 : ScoreW'(raw);
  end

  assign score           = score_r;
  assign candidate_index = cand_r;

  assign sts.is_empty = empty_req;
  assign sts.is_last  = last;
  assign sts.need_std = (score_mode == MODE_WORST_STD) || (score_mode == MODE_MEAN_STD);
  assign sts.need_div = (score_mode == MODE_MEAN_PEN) || (score_mode == MODE_MEAN_TOTAL)
                     || (score_mode == MODE_MEAN_START) || (score_mode == MODE_MEAN_STD);

endmodule

>>> rtl/sample_penalty_scorer.sv
`timescale 1ns / 1ps
// channel | dir | fields (tdata / tuser, low bit first)
// in_     | in  | tdata: tot_cost[27:0], startup_cost[55:28], envelope[83:56]; tlast: last;
//         |     | tuser: empty_req
// out_    | out | tdata: score[28:0], candidate_index[36:29]
// cfg_    | in  | index 0 score_mode, 1 tolerance_q12
// Plain samples are taken back to back. After a last sample the input is held; the
// direct modes load the score straight from the running registers, mean modes divide
// by the count (38-step divider), worst+std and mean+std add square terms, 38-step root, divide.
// in_tready returns the cycle after the word is taken; an empty word goes straight to output.
// Reset is synchronous, active low. The output word holds while out_tready is low.
module sample_penalty_scorer #(
  parameter int unsigned MAX_SAMPLES    = 256,
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // tot_cost, startup_cost, envelope
  input  logic        in_tlast,   // last
  input  logic        in_tuser,   // empty_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // score, candidate_index
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sps_pkg::*;

  logic [ModeW-1:0] mode_r;
  logic [TolW-1:0]  tol_r;
  sps_cmd_t         cmd;
  sps_sts_t         sts;
  logic [ScoreW-1:0] score;
  logic [IdxW-1:0]   cidx;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WORST;
      tol_r  <= 16'd4915;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) mode_r <= cfg_data[ModeW-1:0];
      else                       tol_r  <= cfg_data;
    end
  end

  sps_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );

  sps_dp #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_CANDIDATES(MAX_CANDIDATES)) u_dp (
    .clk, .rst_n,
    .tot_cost(in_tdata[27:0]), .startup_cost(in_tdata[55:28]),
    .envelope(in_tdata[83:56]), .last(in_tlast), .empty_req(in_tuser),
    .score_mode(mode_r), .tolerance_q12(tol_r), .cmd, .sts,
    .score, .candidate_index(cidx)
  );

  assign out_tdata = {3'b0, cidx, score};

endmodule

>>> rtl/sps_checker.sv
`timescale 1ns / 1ps
module sps_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [39:0] out_tdata
);
  // no new sample while a score word waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while score pending");
  // output word holds under stall
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("word changed");
  // valid holds until the word is taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("valid dropped");
  // reserved bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tdata[39:37] == 3'b0) else $error("pad bits set");
endmodule

bind sample_penalty_scorer sps_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
